>>> rtl/bivariate_poly_mul_mod_macros.svh
// Assertion helpers for the top-level RTL. Each expects clk and arst_n in scope.
`ifndef BIVARIATE_POLY_MUL_MOD_MACROS_SVH
`define BIVARIATE_POLY_MUL_MOD_MACROS_SVH

// Same-cycle implication.
`define BPM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpm_pkg;

	typedef enum logic [2:0] {
		OP_LOAD_X  = 3'd0,
		OP_LOAD_Y  = 3'd1,
		OP_CLEAR   = 3'd2,
		OP_COMPUTE = 3'd3,
		OP_READ    = 3'd4
	} op_t;

	// configuration register indexes, byte address is 4*index (8*index when COEFF_BITS > 32)
	localparam logic [2:0] REG_MODULUS = 3'd0;
	localparam logic [2:0] REG_X_OUTER = 3'd1;
	localparam logic [2:0] REG_X_INNER = 3'd2;
	localparam logic [2:0] REG_Y_OUTER = 3'd3;
	localparam logic [2:0] REG_Y_INNER = 3'd4;

	typedef enum logic [1:0] {
		ALU_RED,
		ALU_MUL,
		ALU_ADD
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_sts_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_LOAD,
		ST_READ,
		ST_X_FETCH,
		ST_X_RED,
		ST_Y_FETCH,
		ST_Y_RED,
		ST_MUL,
		ST_Z_FETCH,
		ST_Z_ADD,
		ST_TRIM,
		ST_TRIM_END,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

>>> rtl/bpm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bpm_in_if #(parameter int COEFF_BITS = 32);
	logic                  valid;
	logic                  ready;
	logic [2:0]            op;
	logic [4:0]            outer_idx;
	logic [4:0]            inner_idx;
	logic [COEFF_BITS-1:0] coeff_in;

	modport source (output valid, op, outer_idx, inner_idx, coeff_in, input ready);
	modport sink   (input valid, op, outer_idx, inner_idx, coeff_in, output ready);
endinterface

interface bpm_out_if #(parameter int COEFF_BITS = 32);
	logic                  valid;
	logic                  ready;
	logic [COEFF_BITS-1:0] coeff_out;
	logic [4:0]            row_len;
	logic [4:0]            outer_len;
	logic                  done_res;

	modport source (output valid, coeff_out, row_len, outer_len, done_res, input ready);
	modport sink   (input valid, coeff_out, row_len, outer_len, done_res, output ready);
endinterface

`default_nettype wire

>>> rtl/bivariate_poly_mul_mod.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Fields                                       Handshake
// in        in   op, outer_idx, inner_idx, coeff_in           valid/ready
// out       out  coeff_out, row_len, outer_len, done_res      valid/ready
// apb       in   paddr, pwdata -> modulus and four lengths    psel/penable/pwrite
//
// Load reduces the coefficient before storing it; clear zeroes every store (ZO=2*MAX_OUTER-1,
// ZI=2*MAX_INNER-1). Compute: zero z, reduce each used x coefficient, then for each nonzero
// x coefficient and y coefficient pair reduce y, multiply and add into z, then trim; one shared
// bit-serial modular unit does this arithmetic.
// Reset: a sweep over all ZO*ZI z entries (961 by default) zeroes all stores; no request
// is taken meanwhile, config writes are. A stalled result holds the next request.
module bivariate_poly_mul_mod #(
	parameter int MAX_OUTER  = 16,
	parameter int MAX_INNER  = 16,
	parameter int COEFF_BITS = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [((COEFF_BITS > 32) ? 6 : 5)-1:0] paddr,
	input  wire logic [((COEFF_BITS > 32) ? 64 : 32)-1:0] pwdata,
	output logic      [((COEFF_BITS > 32) ? 64 : 32)-1:0] prdata,
	output logic                            pready,
	bpm_in_if.sink                          in,
	bpm_out_if.source                       out
);

	localparam int PW   = (COEFF_BITS > 32) ? 64 : 32;
	localparam int SL   = (COEFF_BITS > 32) ? 3 : 2;   // log2 of register stride
	localparam int AW   = SL + 3;
	localparam int ZO   = 2 * MAX_OUTER - 1;
	localparam int ZI   = 2 * MAX_INNER - 1;
	localparam int XD   = MAX_OUTER * MAX_INNER;
	localparam int ZD   = ZO * ZI;
	localparam int XAW  = (XD > 1) ? $clog2(XD) : 1;
	localparam int ZAW  = (ZD > 1) ? $clog2(ZD) : 1;
	localparam int ZRW  = (ZO > 1) ? $clog2(ZO) : 1;
	localparam int OCW  = $clog2(MAX_OUTER + 1);
	localparam int ICW  = $clog2(MAX_INNER + 1);
	localparam int ZOW  = $clog2(ZO + 1);
	localparam int ZIW  = $clog2(ZI + 1);

	// ---------------- configuration registers ----------------
	logic [COEFF_BITS-1:0] mod_q;
	logic [4:0]            xol_q, xil_q, yol_q, yil_q;
	logic [2:0]            reg_idx;

	assign reg_idx = paddr[AW-1:SL];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= COEFF_BITS'(2);
			xol_q <= '0;
			xil_q <= '0;
			yol_q <= '0;
			yil_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				bpm_pkg::REG_MODULUS: mod_q <= pwdata[COEFF_BITS-1:0];
				bpm_pkg::REG_X_OUTER: xol_q <= pwdata[4:0];
				bpm_pkg::REG_X_INNER: xil_q <= pwdata[4:0];
				bpm_pkg::REG_Y_OUTER: yol_q <= pwdata[4:0];
				bpm_pkg::REG_Y_INNER: yil_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bpm_pkg::REG_MODULUS: prdata = PW'(mod_q);
			bpm_pkg::REG_X_OUTER: prdata = PW'(xol_q);
			bpm_pkg::REG_X_INNER: prdata = PW'(xil_q);
			bpm_pkg::REG_Y_OUTER: prdata = PW'(yol_q);
			bpm_pkg::REG_Y_INNER: prdata = PW'(yil_q);
			default:              prdata = '0;
		endcase
	end

	// lengths above the store size count as the full size
	logic [OCW-1:0] xo, yo;
	logic [ICW-1:0] xi, yi;
	logic           empty;

	assign xo    = (xol_q > MAX_OUTER) ? OCW'(MAX_OUTER) : OCW'(xol_q);
	assign yo    = (yol_q > MAX_OUTER) ? OCW'(MAX_OUTER) : OCW'(yol_q);
	assign xi    = (xil_q > MAX_INNER) ? ICW'(MAX_INNER) : ICW'(xil_q);
	assign yi    = (yil_q > MAX_INNER) ? ICW'(MAX_INNER) : ICW'(yil_q);
	assign empty = (xo == '0) || (yo == '0) || (xi == '0) || (yi == '0);

	// ---------------- sequencer state ----------------
	bpm_pkg::state_t   state_q, state_nx;
	bpm_pkg::alu_ctl_t alu_ctl;
	bpm_pkg::alu_sts_t alu_sts;
	logic [COEFF_BITS-1:0] alu_a, alu_b, alu_res;

	logic accept;
	logic pend_q;                // shared unit started, result not back yet
	logic sweep_all_q;           // sweep also clears x and y
	logic [ZOW-1:0] so_q;
	logic [ZIW-1:0] si_q;
	logic sweep_last;
	logic [OCW-1:0] a_q, c_q;
	logic [ICW-1:0] b_q, d_q;
	logic x_last, y_last;
	logic [COEFF_BITS-1:0] xv_q;

	// latched request
	logic [4:0]            oi_q, ii_q;
	logic [COEFF_BITS-1:0] cv_q;
	logic                  ld_y_q, rd_z_ok_q, rd_row_ok_q;
	logic                  in_ok, ld_ok;

	// row lengths and product extent
	logic [4:0] row_len_q [ZO];
	logic [4:0] outer_q;
	logic [ZIW-1:0] rl_q, rl_nx;
	logic           tv_s1;
	logic [ZOW-1:0] to_s1;
	logic [ZIW-1:0] ti_s1;

	// output register
	logic                  ovld_q, odone_q;
	logic [COEFF_BITS-1:0] ocoeff_q;
	logic [4:0]            orow_q, oouter_q;

	// memories
	logic [COEFF_BITS-1:0] x_mem [XD];
	logic [COEFF_BITS-1:0] y_mem [XD];
	logic [COEFF_BITS-1:0] z_mem [ZD];
	logic                  x_we, y_we, x_re, y_re, z_we, z_re;
	logic [XAW-1:0]        xy_waddr, x_raddr, y_raddr;
	logic [ZAW-1:0]        z_waddr, z_raddr, sweep_zaddr, acc_zaddr, in_zaddr;
	logic [COEFF_BITS-1:0] xy_wdata, z_wdata, x_rd, y_rd, z_rd;
	logic                  sweep_in_xy;

	assign accept      = in.valid && in.ready;
	assign sweep_last  = (so_q == ZOW'(ZO - 1)) && (si_q == ZIW'(ZI - 1));
	assign x_last      = (a_q == xo - 1'b1) && (b_q == xi - 1'b1);
	assign y_last      = (c_q == yo - 1'b1) && (d_q == yi - 1'b1);
	assign in_ok       = (in.outer_idx < ZO) && (in.inner_idx < ZI);
	assign ld_ok       = (in.outer_idx < MAX_OUTER) && (in.inner_idx < MAX_INNER);
	assign sweep_in_xy = (so_q < MAX_OUTER) && (si_q < MAX_INNER);

	assign sweep_zaddr = ZAW'(int'(so_q) * ZI + int'(si_q));
	assign acc_zaddr   = ZAW'((int'(a_q) + int'(c_q)) * ZI + int'(b_q) + int'(d_q));
	assign in_zaddr    = ZAW'(int'(in.outer_idx) * ZI + int'(in.inner_idx));
	assign x_raddr     = XAW'(int'(a_q) * MAX_INNER + int'(b_q));
	assign y_raddr     = XAW'(int'(c_q) * MAX_INNER + int'(d_q));

	// ---------------- next state ----------------
	always_comb begin
		state_nx = state_q;
		case (state_q)
			bpm_pkg::ST_IDLE: begin
				if (accept) begin
					case (in.op)
						bpm_pkg::OP_LOAD_X, bpm_pkg::OP_LOAD_Y:
							state_nx = ld_ok ? bpm_pkg::ST_LOAD : bpm_pkg::ST_IDLE;
						bpm_pkg::OP_CLEAR, bpm_pkg::OP_COMPUTE:
							state_nx = bpm_pkg::ST_SWEEP;
						bpm_pkg::OP_READ:
							state_nx = bpm_pkg::ST_READ;
						default: state_nx = bpm_pkg::ST_IDLE;
					endcase
				end
			end
			bpm_pkg::ST_SWEEP: begin
				if (sweep_last) begin
					if (sweep_all_q)
						state_nx = bpm_pkg::ST_IDLE;
					else
						state_nx = empty ? bpm_pkg::ST_TRIM : bpm_pkg::ST_X_FETCH;
				end
			end
			bpm_pkg::ST_LOAD: begin
				if (alu_sts.done) state_nx = bpm_pkg::ST_IDLE;
			end
			bpm_pkg::ST_READ:    state_nx = bpm_pkg::ST_IDLE;
			bpm_pkg::ST_X_FETCH: state_nx = bpm_pkg::ST_X_RED;
			bpm_pkg::ST_X_RED: begin
				if (alu_sts.done) begin
					if (alu_res != '0)
						state_nx = bpm_pkg::ST_Y_FETCH;
					else
						state_nx = x_last ? bpm_pkg::ST_TRIM : bpm_pkg::ST_X_FETCH;
				end
			end
			bpm_pkg::ST_Y_FETCH: state_nx = bpm_pkg::ST_Y_RED;
			bpm_pkg::ST_Y_RED: begin
				if (alu_sts.done) state_nx = bpm_pkg::ST_MUL;
			end
			bpm_pkg::ST_MUL: begin
				if (alu_sts.done) state_nx = bpm_pkg::ST_Z_FETCH;
			end
			bpm_pkg::ST_Z_FETCH: state_nx = bpm_pkg::ST_Z_ADD;
			bpm_pkg::ST_Z_ADD: begin
				if (alu_sts.done) begin
					if (!y_last)
						state_nx = bpm_pkg::ST_Y_FETCH;
					else
						state_nx = x_last ? bpm_pkg::ST_TRIM : bpm_pkg::ST_X_FETCH;
				end
			end
			bpm_pkg::ST_TRIM: begin
				if (sweep_last) state_nx = bpm_pkg::ST_TRIM_END;
			end
			bpm_pkg::ST_TRIM_END: state_nx = bpm_pkg::ST_DONE;
			bpm_pkg::ST_DONE:     state_nx = bpm_pkg::ST_IDLE;
			default:              state_nx = bpm_pkg::ST_IDLE;
		endcase
	end

	// ---------------- outputs of the sequencer ----------------
	always_comb begin
		in.ready      = 1'b0;
		alu_ctl.start = 1'b0;
		alu_ctl.op    = bpm_pkg::ALU_RED;
		alu_a         = xv_q;
		alu_b         = cv_q;
		x_we          = 1'b0;
		y_we          = 1'b0;
		xy_waddr      = XAW'(int'(oi_q) * MAX_INNER + int'(ii_q));
		xy_wdata      = alu_res;
		x_re          = 1'b0;
		y_re          = 1'b0;
		z_we          = 1'b0;
		z_waddr       = acc_zaddr;
		z_wdata       = alu_res;
		z_re          = 1'b0;
		z_raddr       = acc_zaddr;
		case (state_q)
			bpm_pkg::ST_IDLE: begin
				in.ready = !ovld_q || out.ready;
				z_re     = accept && in.op == bpm_pkg::OP_READ && in_ok;
				z_raddr  = in_zaddr;
			end
			bpm_pkg::ST_SWEEP: begin
				z_we     = 1'b1;
				z_waddr  = sweep_zaddr;
				z_wdata  = '0;
				x_we     = sweep_all_q && sweep_in_xy;
				y_we     = sweep_all_q && sweep_in_xy;
				xy_waddr = XAW'(int'(so_q) * MAX_INNER + int'(si_q));
				xy_wdata = '0;
			end
			bpm_pkg::ST_LOAD: begin
				alu_ctl.start = !pend_q;
				x_we = alu_sts.done && !ld_y_q;
				y_we = alu_sts.done && ld_y_q;
			end
			bpm_pkg::ST_X_FETCH: x_re = 1'b1;
			bpm_pkg::ST_X_RED: begin
				alu_ctl.start = !pend_q;
				alu_b         = x_rd;
			end
			bpm_pkg::ST_Y_FETCH: y_re = 1'b1;
			bpm_pkg::ST_Y_RED: begin
				alu_ctl.start = !pend_q;
				alu_b         = y_rd;
			end
			bpm_pkg::ST_MUL: begin
				alu_ctl.start = !pend_q;
				alu_ctl.op    = bpm_pkg::ALU_MUL;
				alu_b         = alu_res;
			end
			bpm_pkg::ST_Z_FETCH: z_re = 1'b1;
			bpm_pkg::ST_Z_ADD: begin
				alu_ctl.start = !pend_q;
				alu_ctl.op    = bpm_pkg::ALU_ADD;
				alu_a         = z_rd;
				alu_b         = alu_res;
				z_we          = alu_sts.done;
			end
			bpm_pkg::ST_TRIM: begin
				z_re    = 1'b1;
				z_raddr = sweep_zaddr;
			end
			default: ;
		endcase
	end

	bpm_alu #(
		.COEFF_BITS(COEFF_BITS)
	) u_alu (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (alu_ctl),
		.modulus (mod_q),
		.opa     (alu_a),
		.opb     (alu_b),
		.sts     (alu_sts),
		.res     (alu_res)
	);

	// ---------------- stores ----------------
	always_ff @(posedge clk) begin
		if (x_we) x_mem[xy_waddr] <= xy_wdata;
		if (x_re) x_rd <= x_mem[x_raddr];
	end

	always_ff @(posedge clk) begin
		if (y_we) y_mem[xy_waddr] <= xy_wdata;
		if (y_re) y_rd <= y_mem[y_raddr];
	end

	always_ff @(posedge clk) begin
		if (z_we) z_mem[z_waddr] <= z_wdata;
		if (z_re) z_rd <= z_mem[z_raddr];
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpm_pkg::ST_SWEEP;
			sweep_all_q <= 1'b1;
			so_q        <= '0;
			si_q        <= '0;
			pend_q      <= 1'b0;
			tv_s1       <= 1'b0;
		end else begin
			state_q <= state_nx;
			tv_s1   <= (state_q == bpm_pkg::ST_TRIM);
			if (alu_ctl.start)
				pend_q <= 1'b1;
			else if (alu_sts.done)
				pend_q <= 1'b0;
			if (accept)
				sweep_all_q <= (in.op == bpm_pkg::OP_CLEAR);
			if (state_q == bpm_pkg::ST_SWEEP || state_q == bpm_pkg::ST_TRIM) begin
				if (si_q == ZIW'(ZI - 1)) begin
					si_q <= '0;
					so_q <= sweep_last ? '0 : so_q + 1'b1;
				end else begin
					si_q <= si_q + 1'b1;
				end
			end
		end
	end

	// loop counters over x (a, b) and y (c, d)
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q <= '0;
			b_q <= '0;
			c_q <= '0;
			d_q <= '0;
		end else if ((state_q == bpm_pkg::ST_X_RED && alu_sts.done && alu_res == '0) ||
				(state_q == bpm_pkg::ST_Z_ADD && alu_sts.done && y_last)) begin
			c_q <= '0;
			d_q <= '0;
			if (b_q == xi - 1'b1) begin
				b_q <= '0;
				a_q <= a_q + 1'b1;
			end else begin
				b_q <= b_q + 1'b1;
			end
		end else if (state_q == bpm_pkg::ST_Z_ADD && alu_sts.done) begin
			if (d_q == yi - 1'b1) begin
				d_q <= '0;
				c_q <= c_q + 1'b1;
			end else begin
				d_q <= d_q + 1'b1;
			end
		end
		if (state_q == bpm_pkg::ST_X_RED && alu_sts.done)
			xv_q <= alu_res;
	end

	// request fields, held for multi-cycle work
	always_ff @(posedge clk) begin
		if (accept) begin
			oi_q        <= in.outer_idx;
			ii_q        <= in.inner_idx;
			cv_q        <= in.coeff_in;
			ld_y_q      <= (in.op == bpm_pkg::OP_LOAD_Y);
			rd_z_ok_q   <= in_ok;
			rd_row_ok_q <= (in.outer_idx < ZO);
		end
	end

	// trim: track the last nonzero column of each row as the sweep reads it back
	always_ff @(posedge clk) begin
		to_s1 <= so_q;
		ti_s1 <= si_q;
	end

	assign rl_nx = (z_rd != '0) ? ZIW'(int'(ti_s1) + 1) : rl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ZO; k++) row_len_q[k] <= '0;
			outer_q <= '0;
			rl_q    <= '0;
		end else if (state_q == bpm_pkg::ST_SWEEP && sweep_all_q) begin
			for (int k = 0; k < ZO; k++) row_len_q[k] <= '0;
			outer_q <= '0;
			rl_q    <= '0;
		end else if (accept && in.op == bpm_pkg::OP_COMPUTE) begin
			outer_q <= '0;
			rl_q    <= '0;
		end else if (tv_s1) begin
			if (ti_s1 == ZIW'(ZI - 1)) begin
				row_len_q[ZRW'(to_s1)] <= 5'(rl_nx);
				if (rl_nx != '0) outer_q <= 5'(int'(to_s1) + 1);
				rl_q <= '0;
			end else begin
				rl_q <= rl_nx;
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (state_q == bpm_pkg::ST_READ || state_q == bpm_pkg::ST_DONE) begin
			ovld_q <= 1'b1;
		end else if (out.ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bpm_pkg::ST_READ) begin
			ocoeff_q <= rd_z_ok_q ? z_rd : '0;
			orow_q   <= rd_row_ok_q ? row_len_q[ZRW'(oi_q)] : '0;
			oouter_q <= outer_q;
			odone_q  <= 1'b0;
		end else if (state_q == bpm_pkg::ST_DONE) begin
			ocoeff_q <= '0;
			orow_q   <= '0;
			oouter_q <= outer_q;
			odone_q  <= 1'b1;
		end
	end

	assign out.valid     = ovld_q;
	assign out.coeff_out = ocoeff_q;
	assign out.row_len   = orow_q;
	assign out.outer_len = oouter_q;
	assign out.done_res  = odone_q;

	// ---------------- checks ----------------
`include "bivariate_poly_mul_mod_macros.svh"

	`BPM_ASSERT_NOW(a_alu_start_idle, alu_ctl.start, !alu_sts.busy, "alu started while busy")
	`BPM_ASSERT_NOW(a_done_zero, out.valid && out.done_res, out.coeff_out == '0 && out.row_len == '0, "compute result carries data")
	`BPM_ASSERT_NOW(a_outer_bound, 1'b1, outer_q <= ZO, "outer length past product size")
	`BPM_ASSERT_NOW(a_read_turn, $past(in.valid && in.ready && in.op == bpm_pkg::OP_READ, 2), out.valid, "read result late")

endmodule

`default_nettype wire

>>> rtl/bpm_alu.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared modular unit: reduce and multiply go one operand bit per cycle,
// add skips the serial loop. Modulus zero means plain wrap-around arithmetic.
module bpm_alu #(
	parameter int COEFF_BITS = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire bpm_pkg::alu_ctl_t       ctl,
	input  wire logic [COEFF_BITS-1:0]   modulus,
	input  wire logic [COEFF_BITS-1:0]   opa,
	input  wire logic [COEFF_BITS-1:0]   opb,
	output bpm_pkg::alu_sts_t            sts,
	output logic [COEFF_BITS-1:0]        res
);

	localparam int CW = $clog2(COEFF_BITS + 1);

	logic [COEFF_BITS-1:0] r_q, add_q, b_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q, done_q;
	logic [COEFF_BITS-1:0] dbl, step;

	function automatic logic [COEFF_BITS-1:0] addm(input logic [COEFF_BITS-1:0] a,
			input logic [COEFF_BITS-1:0] b, input logic [COEFF_BITS-1:0] n);
		logic [COEFF_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (n != '0 && s >= {1'b0, n}) begin
			s = s - {1'b0, n};
		end
		return s[COEFF_BITS-1:0];
	endfunction

	// double, then add the addend when the current bit is set
	assign dbl  = addm(r_q, r_q, modulus);
	assign step = addm(dbl, b_q[COEFF_BITS-1] ? add_q : '0, modulus);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				case (ctl.op)
					bpm_pkg::ALU_ADD: begin
						done_q <= 1'b1;
					end
					bpm_pkg::ALU_RED, bpm_pkg::ALU_MUL: begin
						busy_q <= 1'b1;
						cnt_q  <= CW'(COEFF_BITS);
					end
					default: begin
						done_q <= 1'b1;
					end
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			b_q <= opb;
			case (ctl.op)
				bpm_pkg::ALU_ADD: begin
					r_q <= addm(opa, opb, modulus);
				end
				bpm_pkg::ALU_MUL: begin
					r_q   <= '0;
					add_q <= opa;
				end
				default: begin
					r_q   <= '0;
					add_q <= COEFF_BITS'(1);
				end
			endcase
		end else if (busy_q) begin
			r_q <= step;
			b_q <= {b_q[COEFF_BITS-2:0], 1'b0};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign res      = r_q;

endmodule

`default_nettype wire

>>> bench/bivariate_poly_mul_mod_tb.sv
`timescale 1ns / 1ps

module bivariate_poly_mul_mod_tb;

	localparam int MAXO = 16;
	localparam int MAXI = 16;
	localparam int ZO   = 2 * MAXO - 1;
	localparam int ZI   = 2 * MAXI - 1;

	// op codes the block ignores
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	localparam int ITEM_TARGET = 1700;
	// a clear walks the whole z store, so wait past it before touching registers
	localparam int QUIET_CYCLES = ZO * ZI + 64;
	// worst compute here: few nonzero x coefficients against full 16x16 y
	localparam int STALL_LIMIT = 200000;
	localparam int HOLD_AT    = 400;
	localparam int HOLD_LEN   = 2500;

	typedef struct {
		logic [2:0]  op;
		logic [4:0]  oi;
		logic [4:0]  ii;
		logic [31:0] cv;
	} bpm_req_t;

	typedef struct {
		logic [31:0] coeff;
		logic [4:0]  row_len;
		logic [4:0]  outer_len;
		logic        done;
	} bpm_res_t;

	// Product predictor and queue of expected results.
	class bpm_scoreboard;
		logic [31:0] modulus;
		logic [4:0]  xo_len, xi_len, yo_len, yi_len;
		logic [31:0] xs[MAXO*MAXI];
		logic [31:0] ys[MAXO*MAXI];
		logic [31:0] zs[ZO*ZI];
		logic [4:0]  row_lens[ZO];
		logic [4:0]  z_rows;
		bpm_res_t    expected_q[$];

		function new();
			modulus = 2;
			xo_len = 0; xi_len = 0; yo_len = 0; yi_len = 0;
			wipe();
		endfunction

		function void wipe();
			foreach (xs[k]) xs[k] = 0;
			foreach (ys[k]) ys[k] = 0;
			foreach (zs[k]) zs[k] = 0;
			foreach (row_lens[k]) row_lens[k] = 0;
			z_rows = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				bpm_pkg::REG_MODULUS: modulus = v;
				bpm_pkg::REG_X_OUTER: xo_len = v[4:0];
				bpm_pkg::REG_X_INNER: xi_len = v[4:0];
				bpm_pkg::REG_Y_OUTER: yo_len = v[4:0];
				bpm_pkg::REG_Y_INNER: yi_len = v[4:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] red(logic [31:0] a);
			return (modulus == 0) ? a : a % modulus;
		endfunction

		function logic [31:0] add_mod(logic [31:0] a, logic [31:0] b);
			logic [32:0] s;
			s = {1'b0, a} + {1'b0, b};
			if (modulus == 0) return s[31:0];
			return 32'(s % {1'b0, modulus});
		endfunction

		function logic [31:0] mul_mod(logic [31:0] a, logic [31:0] b);
			logic [63:0] p;
			p = {32'd0, a} * {32'd0, b};
			if (modulus == 0) return p[31:0];
			return 32'(p % {32'd0, modulus});
		endfunction

		function int clamp(logic [4:0] v, int m);
			return (int'(v) > m) ? m : int'(v);
		endfunction

		function void multiply();
			int xo, xi, yo, yi, len;
			logic [31:0] xv, pr;
			xo = clamp(xo_len, MAXO); xi = clamp(xi_len, MAXI);
			yo = clamp(yo_len, MAXO); yi = clamp(yi_len, MAXI);
			foreach (zs[k]) zs[k] = 0;
			for (int a = 0; a < xo; a++)
				for (int b = 0; b < xi; b++) begin
					xv = red(xs[a*MAXI+b]);
					if (xv != 0)
						for (int c = 0; c < yo; c++)
							for (int d = 0; d < yi; d++) begin
								pr = mul_mod(xv, red(ys[c*MAXI+d]));
								zs[(a+c)*ZI+b+d] = add_mod(zs[(a+c)*ZI+b+d], pr);
							end
				end
			z_rows = 0;
			for (int o = 0; o < ZO; o++) begin
				len = 0;
				for (int i = 0; i < ZI; i++)
					if (zs[o*ZI+i] != 0) len = i + 1;
				row_lens[o] = 5'(len);
				if (len != 0) z_rows = 5'(o + 1);
			end
		endfunction

		// accepted request: update state, queue any result it causes
		function void note(bpm_req_t r);
			bpm_res_t e;
			e = '{coeff: 0, row_len: 0, outer_len: 0, done: 0};
			case (r.op)
				bpm_pkg::OP_LOAD_X, bpm_pkg::OP_LOAD_Y: begin
					if (r.oi < MAXO && r.ii < MAXI) begin
						if (r.op == bpm_pkg::OP_LOAD_X) xs[r.oi*MAXI+r.ii] = red(r.cv);
						else ys[r.oi*MAXI+r.ii] = red(r.cv);
					end
				end
				bpm_pkg::OP_CLEAR: wipe();
				bpm_pkg::OP_COMPUTE: begin
					multiply();
					e.outer_len = z_rows;
					e.done = 1;
					expected_q.push_back(e);
				end
				bpm_pkg::OP_READ: begin
					if (r.oi < ZO) begin
						e.row_len = row_lens[r.oi];
						if (r.ii < ZI) e.coeff = zs[r.oi*ZI+r.ii];
					end
					e.outer_len = z_rows;
					expected_q.push_back(e);
				end
				default: ;
			endcase
		endfunction

		// returns an empty string when the result matches
		function string check(bpm_res_t g);
			bpm_res_t e;
			if (expected_q.size() == 0)
				return $sformatf("result with nothing expected: coeff=%h row=%0d outer=%0d done=%0b",
					g.coeff, g.row_len, g.outer_len, g.done);
			e = expected_q.pop_front();
			if (g.coeff !== e.coeff || g.row_len !== e.row_len ||
					g.outer_len !== e.outer_len || g.done !== e.done)
				return $sformatf("got coeff=%h row=%0d outer=%0d done=%0b, want %h %0d %0d %0b",
					g.coeff, g.row_len, g.outer_len, g.done,
					e.coeff, e.row_len, e.outer_len, e.done);
			return "";
		endfunction

		function int size();
			return expected_q.size();
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [4:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;

	bpm_in_if  #(.COEFF_BITS(32)) in_ch();
	bpm_out_if #(.COEFF_BITS(32)) out_ch();

	bivariate_poly_mul_mod #(.MAX_OUTER(MAXO), .MAX_INNER(MAXI), .COEFF_BITS(32)) u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in(in_ch), .out(out_ch)
	);

	always #5 clk = ~clk;

	bpm_scoreboard sb = new();
	int errors = 0;
	int items_sent = 0;
	int burst_left = 0;
	int idle_cycles = 0;

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// --- monitors and watchdog, all sampled at the rising edge ---
	always @(posedge clk) begin
		bpm_req_t r;
		bpm_res_t g;
		string msg;
		bit moved;
		moved = 0;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				r = '{op: in_ch.op, oi: in_ch.outer_idx, ii: in_ch.inner_idx,
					cv: in_ch.coeff_in};
				sb.note(r);
				moved = 1;
			end
			if (out_ch.valid && out_ch.ready) begin
				g = '{coeff: out_ch.coeff_out, row_len: out_ch.row_len,
					outer_len: out_ch.outer_len, done: out_ch.done_res};
				msg = sb.check(g);
				if (msg != "") report(msg);
				moved = 1;
			end
			if (psel && penable && pwrite && pready) moved = 1;
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("bivariate_poly_mul_mod_tb: errors");
				$finish;
			end
		end
	end

	// --- result side: stall patterns that change every so often, plus one long
	// hold-off once enough requests went in so the block backs up ---
	int rx_mode = 0, rx_left = 0, rx_cyc = 0, hold_left = 0;
	bit hold_done = 0;
	always @(posedge clk) begin
		if (!hold_done && items_sent >= HOLD_AT) begin
			hold_done = 1;
			hold_left = HOLD_LEN;
		end
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(16, 200);
		end
		rx_left--;
		rx_cyc++;
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= 1'($urandom);
				2: out_ch.ready <= ($urandom_range(0, 3) == 0);
				default: out_ch.ready <= (rx_cyc % 5 != 0);
			endcase
		end
	end

	// --- request side ---
	// called right after a rising edge; returns after acceptance plus any gap
	task automatic send(input logic [2:0] op, input logic [4:0] oi, input logic [4:0] ii,
			input logic [31:0] cv);
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.outer_idx <= oi;
		in_ch.inner_idx <= ii;
		in_ch.coeff_in <= cv;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_reg(idx, v);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_shape(input logic [31:0] m, input logic [4:0] xo, input logic [4:0] xi,
			input logic [4:0] yo, input logic [4:0] yi);
		reg_write(bpm_pkg::REG_MODULUS, m);
		reg_write(bpm_pkg::REG_X_OUTER, {27'd0, xo});
		reg_write(bpm_pkg::REG_X_INNER, {27'd0, xi});
		reg_write(bpm_pkg::REG_Y_OUTER, {27'd0, yo});
		reg_write(bpm_pkg::REG_Y_INNER, {27'd0, yi});
	endtask

	// drop valid, wait for every expected result, then let loads/clears finish
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_coeff();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'($urandom_range(1, 20));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_modulus();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			3, 4: return 32'($urandom_range(2, 50));
			default: return $urandom;
		endcase
	endfunction

	// small shapes mostly; now and then a near-full one, cleared first and
	// with only a few nonzero x coefficients so the multiply stays short
	task automatic random_set();
		bit wide;
		int n, xo, xi, yo, yi, zr, zc;
		wide = ($urandom_range(0, 14) == 0);
		if (wide) begin
			set_shape(pick_modulus(), 5'($urandom_range(12, 31)), 5'($urandom_range(12, 31)),
				5'($urandom_range(12, 31)), 5'($urandom_range(12, 31)));
			send(bpm_pkg::OP_CLEAR, 5'($urandom), 5'($urandom), $urandom);
			n = $urandom_range(1, 3);
			repeat (n) send(bpm_pkg::OP_LOAD_X, 5'($urandom_range(0, 15)),
				5'($urandom_range(0, 15)), pick_coeff());
			repeat ($urandom_range(5, 25))
				send(bpm_pkg::OP_LOAD_Y, 5'($urandom_range(0, 15)), 5'($urandom_range(0, 15)),
					pick_coeff());
			send(bpm_pkg::OP_COMPUTE, 5'($urandom), 5'($urandom), $urandom);
			repeat ($urandom_range(8, 20))
				send(bpm_pkg::OP_READ, 5'($urandom), 5'($urandom), $urandom);
		end else begin
			xo = $urandom_range(0, 4); xi = $urandom_range(0, 4);
			yo = $urandom_range(0, 4); yi = $urandom_range(0, 4);
			set_shape(pick_modulus(), 5'(xo), 5'(xi), 5'(yo), 5'(yi));
			if ($urandom_range(0, 3) == 0)
				send(bpm_pkg::OP_CLEAR, 5'($urandom), 5'($urandom), $urandom);
			repeat ($urandom_range(4, 30)) begin
				case ($urandom_range(0, 19))
					0: send(OP_SPARE_LO + 3'($urandom_range(0, 2)), 5'($urandom), 5'($urandom),
						$urandom);
					1, 2: send(($urandom_range(0, 1) == 0) ? bpm_pkg::OP_LOAD_X
						: bpm_pkg::OP_LOAD_Y, 5'($urandom), 5'($urandom), pick_coeff());
					3: send(bpm_pkg::OP_READ, 5'($urandom), 5'($urandom), $urandom);
					4, 5, 6, 7, 8, 9, 10, 11: send(bpm_pkg::OP_LOAD_X,
						5'($urandom_range(0, (xo > 0) ? xo - 1 : 0)),
						5'($urandom_range(0, (xi > 0) ? xi - 1 : 0)), pick_coeff());
					default: send(bpm_pkg::OP_LOAD_Y,
						5'($urandom_range(0, (yo > 0) ? yo - 1 : 0)),
						5'($urandom_range(0, (yi > 0) ? yi - 1 : 0)), pick_coeff());
				endcase
			end
			send(bpm_pkg::OP_COMPUTE, 5'($urandom), 5'($urandom), $urandom);
			zr = (xo + yo > 1) ? xo + yo - 2 : 0;
			zc = (xi + yi > 1) ? xi + yi - 2 : 0;
			repeat ($urandom_range(6, 30)) begin
				if ($urandom_range(0, 7) == 0)
					send(bpm_pkg::OP_READ, 5'($urandom), 5'($urandom), $urandom);
				else
					send(bpm_pkg::OP_READ, 5'($urandom_range(0, zr)), 5'($urandom_range(0, zc)),
						$urandom);
			end
			if ($urandom_range(0, 9) == 0)
				send(bpm_pkg::OP_COMPUTE, 5'($urandom), 5'($urandom), $urandom);
		end
		drain();
	endtask

	initial begin
		in_ch.valid = 0;
		in_ch.op = bpm_pkg::OP_LOAD_X;
		in_ch.outer_idx = 0;
		in_ch.inner_idx = 0;
		in_ch.coeff_in = 0;
		out_ch.ready = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state: zero product, zero lengths, ignored op code
		send(bpm_pkg::OP_READ, 5'd0, 5'd0, 32'd0);
		send(bpm_pkg::OP_COMPUTE, 5'd0, 5'd0, 32'd0);
		send(OP_SPARE_HI, 5'd31, 5'd31, 32'hFFFF_FFFF);
		drain();

		// full-size corners with oversize lengths (clamped), largest modulus,
		// out-of-range loads, reads at and past the product edge
		set_shape(32'hFFFF_FFFF, 5'd31, 5'd31, 5'd16, 5'd31);
		send(bpm_pkg::OP_LOAD_X, 5'd15, 5'd15, 32'hFFFF_FFFE);
		send(bpm_pkg::OP_LOAD_X, 5'd0, 5'd0, 32'd1);
		send(bpm_pkg::OP_LOAD_Y, 5'd15, 5'd15, 32'hFFFF_FFFE);
		send(bpm_pkg::OP_LOAD_Y, 5'd0, 5'd0, 32'hFFFF_FFFF);
		send(bpm_pkg::OP_LOAD_X, 5'd16, 5'd0, 32'd5);
		send(bpm_pkg::OP_LOAD_Y, 5'd0, 5'd31, 32'd5);
		send(bpm_pkg::OP_COMPUTE, 5'd0, 5'd0, 32'd0);
		send(bpm_pkg::OP_READ, 5'd30, 5'd30, 32'd0);
		send(bpm_pkg::OP_READ, 5'd15, 5'd15, 32'd0);
		send(bpm_pkg::OP_READ, 5'd31, 5'd0, 32'd0);
		send(bpm_pkg::OP_READ, 5'd30, 5'd31, 32'd0);
		drain();

		// no reduction, then a modulus change after loading, then modulus one
		set_shape(32'd0, 5'd1, 5'd1, 5'd1, 5'd1);
		send(bpm_pkg::OP_LOAD_X, 5'd0, 5'd0, 32'hFFFF_FFFF);
		send(bpm_pkg::OP_LOAD_Y, 5'd0, 5'd0, 32'hFFFF_FFFF);
		send(bpm_pkg::OP_COMPUTE, 5'd0, 5'd0, 32'd0);
		send(bpm_pkg::OP_READ, 5'd0, 5'd0, 32'd0);
		drain();
		reg_write(bpm_pkg::REG_MODULUS, 32'd7);
		send(bpm_pkg::OP_COMPUTE, 5'd0, 5'd0, 32'd0);
		send(bpm_pkg::OP_READ, 5'd0, 5'd0, 32'd0);
		drain();
		reg_write(bpm_pkg::REG_MODULUS, 32'd1);
		send(bpm_pkg::OP_COMPUTE, 5'd0, 5'd0, 32'd0);
		send(bpm_pkg::OP_CLEAR, 5'd0, 5'd0, 32'd0);
		send(bpm_pkg::OP_READ, 5'd0, 5'd0, 32'd0);
		drain();

		while (items_sent < ITEM_TARGET) random_set();

		if (errors == 0 && sb.size() == 0)
			$display("bivariate_poly_mul_mod_tb: clean");
		else
			$display("bivariate_poly_mul_mod_tb: errors");
		$finish;
	end

endmodule
